// ----- hw/rtl/tmi_pkg.sv -----
`default_nettype none

package tmi_pkg;

	localparam logic OPC_LOAD = 1'b0;
	localparam logic OPC_EXEC = 1'b1;

	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;

	typedef struct packed {
		logic       opcode;
		logic [7:0] program_byte;
		logic       end_of_program;
		logic [7:0] console_byte;
	} tmi_item_t;

	typedef struct packed {
		logic       print_valid;
		logic [7:0] print_byte;
		logic       console_used;
		logic       halted;
		logic       bracket_error;
	} tmi_result_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_RIGHT,
		OP_LEFT,
		OP_INC,
		OP_DEC,
		OP_OUT,
		OP_IN,
		OP_OPEN,
		OP_CLOSE
	} tmi_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic accept_en;
		logic load_en;
		logic decode_en;
		logic scan_fwd_en;
		logic scan_bwd_en;
		logic push_en;
	} tmi_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic active;
		logic jump_fwd;
		logic jump_bwd;
		logic scan_done;
	} tmi_sts_t;

	function automatic tmi_op_t decode_op(input logic [7:0] ch);
		tmi_op_t op;
		case (ch)
			CH_RIGHT: op = OP_RIGHT;
			CH_LEFT:  op = OP_LEFT;
			CH_INC:   op = OP_INC;
			CH_DEC:   op = OP_DEC;
			CH_OUT:   op = OP_OUT;
			CH_IN:    op = OP_IN;
			CH_OPEN:  op = OP_OPEN;
			CH_CLOSE: op = OP_CLOSE;
			default:  op = OP_NOP;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tmi_ctrl.sv -----
`default_nettype none

module tmi_ctrl
	import tmi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire logic     cmd_opcode,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output tmi_ctl_t      ctl,
	input  wire tmi_sts_t sts
);

	typedef enum logic [4:0] {
		ST_CLEAR    = 5'b00001,
		ST_IDLE     = 5'b00010,
		ST_DECODE   = 5'b00100,
		ST_SCAN_FWD = 5'b01000,
		ST_SCAN_BWD = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   pending_q, pending_d;
	logic   rsp_valid_q;
	logic   slot_free, push, accept, exec_go, finish;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign push      = (state_q == ST_IDLE) && pending_q && slot_free;
	assign cmd_stall = (state_q != ST_IDLE) || (pending_q && !slot_free);
	assign accept    = cmd_valid && !cmd_stall;
	assign exec_go   = accept && (cmd_opcode == OPC_EXEC) && sts.active;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctl.clear_en    = (state_q == ST_CLEAR);
		ctl.accept_en   = accept;
		ctl.load_en     = accept && (cmd_opcode == OPC_LOAD);
		ctl.decode_en   = (state_q == ST_DECODE);
		ctl.scan_fwd_en = (state_q == ST_SCAN_FWD);
		ctl.scan_bwd_en = (state_q == ST_SCAN_BWD);
		ctl.push_en     = push;
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (exec_go) state_d = ST_DECODE;
				else if (accept) finish = 1'b1;
			end
			ST_DECODE: begin
				if (sts.jump_fwd) state_d = ST_SCAN_FWD;
				else if (sts.jump_bwd) state_d = ST_SCAN_BWD;
				else begin
					state_d = ST_IDLE;
					finish  = 1'b1;
				end
			end
			ST_SCAN_FWD, ST_SCAN_BWD: begin
				if (sts.scan_done) begin
					state_d = ST_IDLE;
					finish  = 1'b1;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// A new result may be set up in the same cycle that the previous one moves out.
	always_comb begin
		if (finish) pending_d = 1'b1;
		else if (push) pending_d = 1'b0;
		else pending_d = pending_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pending_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pending_q   <= pending_d;
			rsp_valid_q <= push || (rsp_valid_q && rsp_stall);
		end
	end

	a_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> (state_q == ST_IDLE))
		else $error("result pending outside idle");

	a_no_reclear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("tape clear restarted");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN_FWD || state_q == ST_SCAN_BWD) && sts.scan_done)
		|=> (state_q == ST_IDLE && pending_q))
		else $error("bracket scan ended without a result");

endmodule

`default_nettype wire

// ----- hw/rtl/tmi_datapath.sv -----
`default_nettype none

module tmi_datapath
	import tmi_pkg::*;
#(
	parameter int CELL_COUNT    = 32768,
	parameter int PROGRAM_DEPTH = 4096
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tmi_ctl_t  ctl,
	output tmi_sts_t       sts,
	input  wire tmi_item_t item,
	output tmi_result_t    result
);

	localparam int CPW = $clog2(CELL_COUNT);
	localparam int PAW = $clog2(PROGRAM_DEPTH);
	localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
	localparam logic [CPW-1:0] CELL_LAST = CPW'(CELL_COUNT - 1);
	localparam logic [PCW-1:0] PROG_FULL = PCW'(PROGRAM_DEPTH);

	logic [7:0] prog_mem [PROGRAM_DEPTH];
	logic [7:0] tape_mem [CELL_COUNT];
	logic [7:0] prog_rd_q, tape_rd_q;

	logic [PCW-1:0] pc_q, len_q, lc_q, nest_q, sp_q;
	logic [CPW-1:0] ptr_q, clr_q;
	logic           err_q;
	logic [7:0]     console_q, pb_q;
	logic           pv_q, cu_q;
	tmi_result_t    out_q;

	tmi_op_t        op, scan_op;
	logic           cell_zero;
	logic [PCW-1:0] pc_inc, pc_dec, sp_inc, sp_dec, lc_inc, prog_raddr;
	logic           open_skip, close_back, fwd_ok, bwd_ok;
	logic           hit_f, hit_b, bound_f, bound_b, scan_hit, scan_bound;
	logic           tape_we;
	logic [CPW-1:0] tape_waddr;
	logic [7:0]     tape_wdata;

	assign op        = decode_op(prog_rd_q);
	assign scan_op   = op;
	assign cell_zero = (tape_rd_q == 8'd0);
	assign pc_inc    = pc_q + PCW'(1);
	assign pc_dec    = pc_q - PCW'(1);
	assign sp_inc    = sp_q + PCW'(1);
	assign sp_dec    = sp_q - PCW'(1);
	assign lc_inc    = (lc_q < PROG_FULL) ? lc_q + PCW'(1) : lc_q;

	assign open_skip  = (op == OP_OPEN) && cell_zero;
	assign close_back = (op == OP_CLOSE) && !cell_zero;
	assign fwd_ok     = (pc_inc < len_q);
	assign bwd_ok     = (pc_q != '0);

	// Forward and backward scans read one program byte per cycle.
	assign hit_f      = (scan_op == OP_CLOSE) && (nest_q == '0);
	assign hit_b      = (scan_op == OP_OPEN) && (nest_q == '0);
	assign bound_f    = (sp_inc >= len_q);
	assign bound_b    = (sp_q == '0);
	assign scan_hit   = ctl.scan_fwd_en ? hit_f : hit_b;
	assign scan_bound = ctl.scan_fwd_en ? bound_f : bound_b;

	always_comb begin
		sts.clear_last = (clr_q == CELL_LAST);
		sts.active     = !err_q && (pc_q < len_q);
		sts.jump_fwd   = open_skip && fwd_ok;
		sts.jump_bwd   = close_back && bwd_ok;
		sts.scan_done  = scan_hit || scan_bound;
	end

	always_comb begin
		if (ctl.decode_en) prog_raddr = sts.jump_fwd ? pc_inc : pc_dec;
		else if (ctl.scan_fwd_en) prog_raddr = sp_inc;
		else if (ctl.scan_bwd_en) prog_raddr = sp_dec;
		else prog_raddr = pc_q;
	end

	always_comb begin
		tape_we    = 1'b0;
		tape_waddr = ptr_q;
		tape_wdata = 8'd0;
		if (ctl.clear_en) begin
			tape_we    = 1'b1;
			tape_waddr = clr_q;
		end else if (ctl.decode_en) begin
			case (op)
				OP_INC: begin
					tape_we    = 1'b1;
					tape_wdata = tape_rd_q + 8'd1;
				end
				OP_DEC: begin
					tape_we    = 1'b1;
					tape_wdata = tape_rd_q - 8'd1;
				end
				OP_IN: begin
					tape_we    = 1'b1;
					tape_wdata = console_q;
				end
				default: tape_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_en && (lc_q < PROG_FULL)) prog_mem[lc_q[PAW-1:0]] <= item.program_byte;
		prog_rd_q <= prog_mem[prog_raddr[PAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
		tape_rd_q <= tape_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			len_q  <= '0;
			lc_q   <= '0;
			nest_q <= '0;
			ptr_q  <= '0;
			clr_q  <= '0;
			err_q  <= 1'b0;
		end else begin
			if (ctl.clear_en) clr_q <= clr_q + CPW'(1);
			if (ctl.load_en) begin
				if (item.end_of_program) begin
					len_q <= lc_inc;
					lc_q  <= '0;
					pc_q  <= '0;
					err_q <= 1'b0;
				end else begin
					lc_q <= lc_inc;
				end
			end
			if (ctl.decode_en) begin
				case (op)
					OP_RIGHT: ptr_q <= (ptr_q == CELL_LAST) ? '0 : ptr_q + CPW'(1);
					OP_LEFT:  ptr_q <= (ptr_q == '0) ? CELL_LAST : ptr_q - CPW'(1);
					default:  ptr_q <= ptr_q;
				endcase
				if (sts.jump_fwd || sts.jump_bwd) begin
					nest_q <= '0;
				end else if ((open_skip && !fwd_ok) || (close_back && !bwd_ok)) begin
					err_q <= 1'b1;
					pc_q  <= len_q;
				end else begin
					pc_q <= pc_inc;
				end
			end
			if (ctl.scan_fwd_en || ctl.scan_bwd_en) begin
				if (scan_hit) begin
					pc_q <= sp_inc;
				end else if (scan_bound) begin
					err_q  <= 1'b1;
					pc_q   <= len_q;
					nest_q <= '0;
				end else if ((ctl.scan_fwd_en && scan_op == OP_OPEN)
					|| (ctl.scan_bwd_en && scan_op == OP_CLOSE)) begin
					nest_q <= nest_q + PCW'(1);
				end else if ((ctl.scan_fwd_en && scan_op == OP_CLOSE)
					|| (ctl.scan_bwd_en && scan_op == OP_OPEN)) begin
					nest_q <= nest_q - PCW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.decode_en) begin
			if (sts.jump_fwd) sp_q <= pc_inc;
			else if (sts.jump_bwd) sp_q <= pc_dec;
		end else if (ctl.scan_fwd_en) begin
			sp_q <= sp_inc;
		end else if (ctl.scan_bwd_en) begin
			sp_q <= sp_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept_en) begin
			console_q <= item.console_byte;
			pv_q      <= 1'b0;
			pb_q      <= 8'd0;
			cu_q      <= 1'b0;
		end else if (ctl.decode_en) begin
			if (op == OP_OUT) begin
				pv_q <= 1'b1;
				pb_q <= tape_rd_q;
			end
			if (op == OP_IN) cu_q <= 1'b1;
		end
		if (ctl.push_en) begin
			out_q.print_valid   <= pv_q;
			out_q.print_byte    <= pb_q;
			out_q.console_used  <= cu_q;
			out_q.halted        <= (pc_q >= len_q);
			out_q.bracket_error <= err_q;
		end
	end

	assign result = out_q;

	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= len_q)
		else $error("program counter beyond program end");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= CELL_LAST)
		else $error("cell pointer beyond tape");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(lc_q <= PROG_FULL) && (len_q <= PROG_FULL))
		else $error("load count beyond program store");

endmodule

`default_nettype wire

// ----- hw/rtl/tape_machine_interpreter_unit.sv -----
// Load transfer: the byte is written to the program store on acceptance, then the result is registered.
// Plain instruction: fetch of program byte and cell, then decode and write-back, then the
// result is registered.
// Bracket jump: decode, then a scan of the program store for the matching bracket.
// Reset: the tape is cleared one cell per cycle, every cell, with cmd_stall high.
`default_nettype none

module tape_machine_interpreter_unit
	import tmi_pkg::*;
#(
	parameter int CELL_COUNT    = 32768,
	parameter int PROGRAM_DEPTH = 4096
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire tmi_item_t cmd,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output tmi_result_t    rsp
);

	tmi_ctl_t ctl;
	tmi_sts_t sts;

	tmi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_opcode (cmd.opcode),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.ctl        (ctl),
		.sts        (sts)
	);

	tmi_datapath #(
		.CELL_COUNT    (CELL_COUNT),
		.PROGRAM_DEPTH (PROGRAM_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.item   (cmd),
		.result (rsp)
	);

endmodule

`default_nettype wire

// ----- tb/tape_machine_checker.sv -----
module tape_machine_checker
	import tmi_pkg::*;
#(
	parameter int CELL_COUNT    = 32768,
	parameter int PROGRAM_DEPTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire logic        cmd_stall,
	input  wire tmi_item_t   cmd,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire tmi_result_t rsp,
	output int unsigned      pending,
	output int unsigned      fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0]  tape [CELL_COUNT];
	logic [7:0]  code_store [PROGRAM_DEPTH];
	int unsigned code_len;
	int unsigned pc;
	int unsigned cell_ptr;
	int unsigned load_addr;
	logic        scan_error;
	int unsigned mismatches;
	tmi_result_t results_due [$];
	tmi_result_t want;

	// Applies one input transfer to the shadow machine and returns the result it must produce.
	function automatic tmi_result_t interpret_item(tmi_item_t it);
		tmi_result_t res;
		int unsigned p;
		int unsigned depth;
		logic        found;
		logic [7:0]  ch;
		res = '0;
		if (it.opcode == OPC_LOAD) begin
			if (load_addr < PROGRAM_DEPTH) begin
				code_store[load_addr] = it.program_byte;
				load_addr++;
			end
			if (it.end_of_program) begin
				code_len = load_addr;
				load_addr = 0;
				pc = 0;
				scan_error = 1'b0;
			end
		end else if (!scan_error && pc < code_len) begin
			ch = code_store[pc];
			pc++;
			case (ch)
				CH_RIGHT: cell_ptr = (cell_ptr == CELL_COUNT - 1) ? 0 : cell_ptr + 1;
				CH_LEFT:  cell_ptr = (cell_ptr == 0) ? CELL_COUNT - 1 : cell_ptr - 1;
				CH_INC:   tape[cell_ptr] = tape[cell_ptr] + 8'd1;
				CH_DEC:   tape[cell_ptr] = tape[cell_ptr] - 8'd1;
				CH_OUT: begin
					res.print_valid = 1'b1;
					res.print_byte = tape[cell_ptr];
				end
				CH_IN: begin
					res.console_used = 1'b1;
					tape[cell_ptr] = it.console_byte;
				end
				CH_OPEN: begin
					if (tape[cell_ptr] == 8'h00) begin
						p = pc - 1;
						depth = 0;
						found = 1'b0;
						while (!found && !scan_error) begin
							p++;
							if (p >= code_len) begin
								scan_error = 1'b1;
							end else if (code_store[p] == CH_OPEN) begin
								depth++;
							end else if (code_store[p] == CH_CLOSE) begin
								if (depth == 0) found = 1'b1;
								else depth--;
							end
						end
						pc = scan_error ? code_len : p + 1;
					end
				end
				CH_CLOSE: begin
					if (tape[cell_ptr] != 8'h00) begin
						p = pc - 1;
						depth = 0;
						found = 1'b0;
						while (!found && !scan_error) begin
							if (p == 0) begin
								scan_error = 1'b1;
							end else begin
								p--;
								if (code_store[p] == CH_CLOSE) begin
									depth++;
								end else if (code_store[p] == CH_OPEN) begin
									if (depth == 0) found = 1'b1;
									else depth--;
								end
							end
						end
						pc = scan_error ? code_len : p + 1;
					end
				end
				default: ;
			endcase
		end
		res.halted = (pc >= code_len);
		res.bracket_error = scan_error;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (tape[i]) tape[i] = 8'h00;
			foreach (code_store[i]) code_store[i] = 8'h00;
			code_len = 0;
			pc = 0;
			cell_ptr = 0;
			load_addr = 0;
			scan_error = 1'b0;
			mismatches = 0;
			results_due.delete();
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cmd_valid && !cmd_stall) results_due.push_back(interpret_item(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result transfer with nothing outstanding: pv=%0b pb=%02h cu=%0b halt=%0b err=%0b",
							$realtime, rsp.print_valid, rsp.print_byte, rsp.console_used,
							rsp.halted, rsp.bracket_error);
				end else begin
					want = results_due.pop_front();
					if (rsp.print_valid !== want.print_valid || rsp.print_byte !== want.print_byte ||
							rsp.console_used !== want.console_used || rsp.halted !== want.halted ||
							rsp.bracket_error !== want.bracket_error) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: expected pv=%0b pb=%02h cu=%0b halt=%0b err=%0b, got pv=%0b pb=%02h cu=%0b halt=%0b err=%0b",
								$realtime, want.print_valid, want.print_byte, want.console_used,
								want.halted, want.bracket_error, rsp.print_valid, rsp.print_byte,
								rsp.console_used, rsp.halted, rsp.bracket_error);
					end
				end
			end
			pending <= results_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tmi_pkg::*;

	// Small sizes keep the reset clear short and make pointer wrap and store full reachable.
	localparam int CELLS = 256;
	localparam int DEPTH = 64;
	localparam int ITEM_TARGET = 2000;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	tmi_item_t   cmd;
	logic        rsp_valid;
	logic        rsp_stall;
	tmi_result_t rsp;
	int unsigned pending;
	int unsigned fail_count;
	int unsigned items_sent;
	logic        steady;
	logic [7:0]  program_text [$];

	tape_machine_interpreter_unit #(
		.CELL_COUNT(CELLS),
		.PROGRAM_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	tape_machine_checker #(
		.CELL_COUNT(CELLS),
		.PROGRAM_DEPTH(DEPTH)
	) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.pending(pending),
		.fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_stall <= !steady && ($urandom_range(0, 99) < 17);
	end

	task automatic send_item(input logic opc, input logic [7:0] pbyte, input logic eop,
			input logic [7:0] cbyte);
		tmi_item_t it;
		it.opcode = opc;
		it.program_byte = pbyte;
		it.end_of_program = eop;
		it.console_byte = cbyte;
		while (!steady && $urandom_range(0, 99) < 17) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic load_text(input logic with_end);
		foreach (program_text[i])
			send_item(OPC_LOAD, program_text[i], with_end && (i == program_text.size() - 1),
				8'($urandom_range(0, 255)));
	endtask

	task automatic run_steps(input int unsigned count);
		repeat (count)
			send_item(OPC_EXEC, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)));
	endtask

	// Holds off new transfers until every result has come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Mostly balanced loops; unbalanced text gets stray and unclosed brackets.
	task automatic build_program(input int unsigned len, input logic balanced);
		int unsigned depth;
		int unsigned r;
		program_text.delete();
		depth = 0;
		for (int unsigned i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (balanced && depth != 0 && depth >= len - i) begin
				program_text.push_back(CH_CLOSE);
				depth--;
			end else if (r < 12 && (!balanced || depth + 2 <= len - i)) begin
				program_text.push_back(CH_OPEN);
				depth++;
			end else if (r < 22 && (depth != 0 || !balanced)) begin
				program_text.push_back(CH_CLOSE);
				if (depth != 0) depth--;
			end else if (r < 30) begin
				program_text.push_back(CH_IN);
			end else if (r < 38) begin
				program_text.push_back(CH_OUT);
			end else if (r < 43) begin
				program_text.push_back(8'($urandom_range(0, 255)));
			end else if (r < 60) begin
				program_text.push_back(CH_INC);
			end else if (r < 76) begin
				program_text.push_back(CH_DEC);
			end else if (r < 88) begin
				program_text.push_back(CH_RIGHT);
			end else begin
				program_text.push_back(CH_LEFT);
			end
		end
	endtask

	initial begin
		int unsigned len;
		int unsigned kind;
		int unsigned programs;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		steady = 1'b0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Nothing loaded yet, so an execute just reports the halt.
		send_item(OPC_EXEC, 8'h00, 1'b0, 8'h00);

		// Pointer wraps both ways, cell wraps up and down, read of 0xFF, print,
		// a skipped loop over a non-command byte, then executes past the end.
		program_text = {CH_LEFT, CH_IN, CH_OUT, CH_INC, CH_OUT, CH_OPEN, 8'h00, CH_CLOSE,
			CH_RIGHT, CH_DEC};
		load_text(1'b1);
		repeat (10) send_item(OPC_EXEC, 8'h00, 1'b0, 8'hFF);

		// The cell is nonzero, so a lone close bracket scans back off the start.
		program_text = {CH_CLOSE};
		load_text(1'b1);
		repeat (2) send_item(OPC_EXEC, 8'h00, 1'b0, 8'h00);

		// A zero cell makes a lone open bracket scan off the end; later executes are ignored.
		program_text = {CH_IN, CH_OPEN};
		load_text(1'b1);
		repeat (3) send_item(OPC_EXEC, 8'h00, 1'b0, 8'h00);

		programs = 0;
		while (items_sent < ITEM_TARGET) begin
			steady = (items_sent >= 700 && items_sent < 1000);
			kind = $urandom_range(0, 99);
			if (kind < 5) len = DEPTH + $urandom_range(1, 4);
			else if (kind < 15) len = $urandom_range(24, DEPTH);
			else len = $urandom_range(1, 16);
			build_program(len, $urandom_range(0, 99) < 85);
			load_text(1'b1);
			if (programs == 6 || $urandom_range(0, 99) < 4) drain();
			run_steps($urandom_range(len / 2 + 1, 2 * len + 6));
			if ($urandom_range(0, 99) < 10) begin
				// Overwrite the start of the running program without an end mark.
				build_program($urandom_range(1, 8), 1'b0);
				load_text(1'b0);
				run_steps($urandom_range(1, 12));
			end
			programs++;
		end

		drain();
		repeat (DEPTH + 20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tape_machine_interpreter_unit regression: pass");
		end else begin
			$display("tape_machine_interpreter_unit regression: fail");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tape_machine_interpreter_unit regression: fail");
		$finish;
	end

endmodule

// ----- tape_machine_interpreter_unit.f -----
hw/rtl/tmi_pkg.sv
hw/rtl/tmi_ctrl.sv
hw/rtl/tmi_datapath.sv
hw/rtl/tape_machine_interpreter_unit.sv
tb/tape_machine_checker.sv
tb/tb_top.sv
